### sv/ioal_pkg.sv
package ioal_pkg;

  localparam int FRACTION_BITS_DEFAULT = 8;
  localparam int OUT_W = 25;
  localparam int ALPHA_W = 17;
  localparam int SAMPLE_W = 16;
  localparam int NUM_CHANNELS = 9;
  localparam int CHAN_W = $clog2(NUM_CHANNELS);
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd55706;

  typedef enum logic [1:0] {
    SENSOR_ACCEL = 2'd0,
    SENSOR_GYRO  = 2'd1,
    SENSOR_MAG   = 2'd2
  } sensor_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    REG_ALPHA_Q16     = 3'd0,
    REG_GYRO_OFFSET_X = 3'd1,
    REG_GYRO_OFFSET_Y = 3'd2,
    REG_GYRO_OFFSET_Z = 3'd3,
    REG_INVERT_ACCEL  = 3'd4
  } reg_index_t;

endpackage

### sv/ioal_in_if.sv
interface ioal_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] sensor;
  logic [1:0] axis;
  logic [7:0] first_byte;
  logic [7:0] second_byte;

  modport source (output valid, output sensor, output axis, output first_byte,
                  output second_byte, input ready);
  modport sink (input valid, input sensor, input axis, input first_byte,
                input second_byte, output ready);
endinterface

### sv/ioal_out_if.sv
interface ioal_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       out_sensor;
  logic [1:0]                       out_axis;
  logic signed [ioal_pkg::OUT_W-1:0] filtered_value;

  modport source (output valid, output out_sensor, output out_axis,
                  output filtered_value, input ready);
  modport sink (input valid, input out_sensor, input out_axis,
                input filtered_value, output ready);
endinterface

### sv/imu_axis_offset_lowpass.sv
// An accepted sample passes the input register, then the result register. Throughput:
// one sample per cycle while the result side does not stall; the filter update of a
// channel reads and writes its state in the same cycle, so samples of one channel
// may follow each other directly. Reset (rst, synchronous) empties both stages,
// clears all nine filter states to zero and loads the register defaults.
module imu_axis_offset_lowpass #(
  parameter int FRACTION_BITS = ioal_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  ioal_in_if.sink                           samples,
  ioal_out_if.source                        results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ioal_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ioal_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ioal_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  // Filter state holds X = x * 2^FRACTION_BITS with x up to 17 bits signed.
  localparam int SW = ioal_pkg::SAMPLE_W + 1 + FRACTION_BITS;
  localparam int EW = (SW > ioal_pkg::OUT_W) ? SW : ioal_pkg::OUT_W;
  localparam int PW = SW + 1 + ioal_pkg::ALPHA_W + 1;

  // Configuration registers.
  logic [ioal_pkg::ALPHA_W-1:0]         alpha_q16;
  logic signed [ioal_pkg::SAMPLE_W-1:0] gyro_offset_x;
  logic signed [ioal_pkg::SAMPLE_W-1:0] gyro_offset_y;
  logic signed [ioal_pkg::SAMPLE_W-1:0] gyro_offset_z;
  logic                                 invert_accel;

  logic                   cfg_write;
  ioal_pkg::reg_index_t   cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = ioal_pkg::reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q16     <= ioal_pkg::ALPHA_RESET;
      gyro_offset_x <= '0;
      gyro_offset_y <= '0;
      gyro_offset_z <= '0;
      invert_accel  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        ioal_pkg::REG_ALPHA_Q16:     alpha_q16 <= pwdata[ioal_pkg::ALPHA_W-1:0];
        ioal_pkg::REG_GYRO_OFFSET_X: gyro_offset_x <= pwdata[ioal_pkg::SAMPLE_W-1:0];
        ioal_pkg::REG_GYRO_OFFSET_Y: gyro_offset_y <= pwdata[ioal_pkg::SAMPLE_W-1:0];
        ioal_pkg::REG_GYRO_OFFSET_Z: gyro_offset_z <= pwdata[ioal_pkg::SAMPLE_W-1:0];
        ioal_pkg::REG_INVERT_ACCEL:  invert_accel <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      ioal_pkg::REG_ALPHA_Q16:
        prdata = ioal_pkg::APB_DATA_W'(alpha_q16);
      ioal_pkg::REG_GYRO_OFFSET_X:
        prdata = ioal_pkg::APB_DATA_W'(unsigned'(gyro_offset_x));
      ioal_pkg::REG_GYRO_OFFSET_Y:
        prdata = ioal_pkg::APB_DATA_W'(unsigned'(gyro_offset_y));
      ioal_pkg::REG_GYRO_OFFSET_Z:
        prdata = ioal_pkg::APB_DATA_W'(unsigned'(gyro_offset_z));
      ioal_pkg::REG_INVERT_ACCEL:
        prdata = ioal_pkg::APB_DATA_W'(invert_accel);
      default:
        prdata = '0;
    endcase
  end

  // Input register.
  logic       s1_valid;
  logic [1:0] s1_sensor;
  logic [1:0] s1_axis;
  logic [7:0] s1_first;
  logic [7:0] s1_second;
  logic       s1_move;
  logic       in_accept;
  logic       in_codes_ok;

  // Result register.
  logic                           out_valid;
  logic [1:0]                     out_sensor;
  logic [1:0]                     out_axis;
  logic signed [ioal_pkg::OUT_W-1:0] out_value;

  assign s1_move       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || s1_move;
  assign in_accept     = samples.valid && samples.ready;
  // Items with an undefined sensor or axis code are accepted and dropped here.
  assign in_codes_ok   = (samples.sensor <= ioal_pkg::SENSOR_MAG)
                      && (samples.axis <= ioal_pkg::AXIS_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= in_accept && in_codes_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sensor <= samples.sensor;
      s1_axis   <= samples.axis;
      s1_first  <= samples.first_byte;
      s1_second <= samples.second_byte;
    end
  end

  // Filter datapath.
  logic signed [SW-1:0]                 state [ioal_pkg::NUM_CHANNELS];
  logic [ioal_pkg::CHAN_W-1:0]          chan;
  logic signed [ioal_pkg::SAMPLE_W-1:0] word;
  logic signed [ioal_pkg::SAMPLE_W-1:0] offset;
  logic signed [ioal_pkg::SAMPLE_W:0]   x;
  logic signed [SW-1:0]                 xs;
  logic signed [SW-1:0]                 s_old;
  logic signed [SW:0]                   diff;
  logic [ioal_pkg::ALPHA_W-1:0]         alpha_sat;
  logic signed [ioal_pkg::ALPHA_W:0]    alpha_s;
  logic signed [PW-1:0]                 prod;
  logic signed [SW:0]                   step;
  logic signed [SW-1:0]                 s_new;
  logic signed [SW-1:0]                 res;
  logic signed [EW-1:0]                 res_ext;
  logic                                 negate;

  assign chan = ioal_pkg::CHAN_W'({s1_sensor, 1'b0}) + ioal_pkg::CHAN_W'(s1_sensor)
              + ioal_pkg::CHAN_W'(s1_axis);

  always_comb begin
    if (s1_sensor == ioal_pkg::SENSOR_ACCEL) begin
      word = {s1_second, s1_first};
    end else begin
      word = {s1_first, s1_second};
    end
    case (s1_axis)
      ioal_pkg::AXIS_X: offset = gyro_offset_x;
      ioal_pkg::AXIS_Y: offset = gyro_offset_y;
      default:          offset = gyro_offset_z;
    endcase
    if (s1_sensor == ioal_pkg::SENSOR_GYRO) begin
      x = (ioal_pkg::SAMPLE_W+1)'(word) - (ioal_pkg::SAMPLE_W+1)'(offset);
    end else begin
      x = (ioal_pkg::SAMPLE_W+1)'(word);
    end
    alpha_sat = (alpha_q16 > ioal_pkg::ALPHA_ONE) ? ioal_pkg::ALPHA_ONE : alpha_q16;
    alpha_s   = signed'({1'b0, alpha_sat});
    xs        = {x, {FRACTION_BITS{1'b0}}};
    s_old     = state[chan];
    diff      = (SW+1)'(xs) - (SW+1)'(s_old);
    prod      = PW'(diff) * PW'(alpha_s);
    // An arithmetic shift floors negative products toward minus infinity.
    step      = prod[SW+16:16];
    s_new     = SW'((SW+1)'(s_old) + step);
    negate    = invert_accel && (s1_sensor == ioal_pkg::SENSOR_ACCEL)
             && (s1_axis != ioal_pkg::AXIS_Y);
    res       = negate ? -s_new : s_new;
    res_ext   = EW'(res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ioal_pkg::NUM_CHANNELS; i++) begin
        state[i] <= '0;
      end
    end else if (s1_move) begin
      state[chan] <= s_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_sensor <= s1_sensor;
      out_axis   <= s1_axis;
      out_value  <= res_ext[ioal_pkg::OUT_W-1:0];
    end
  end

  assign results.valid          = out_valid;
  assign results.out_sensor     = out_sensor;
  assign results.out_axis       = out_axis;
  assign results.filtered_value = out_value;

  // A stalled sample in the input register must not be dropped.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid)
    else $error("input stage lost a sample while stalled");

  // A sample with an undefined sensor or axis code never reaches the filter.
  a_drop_bad_code: assert property (@(posedge clk) disable iff (rst)
    in_accept && !in_codes_ok |=> !s1_valid)
    else $error("sample with undefined code entered the filter stage");

  // Every filter update produces a result in the next cycle.
  a_update_result: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("filter update without a result");

endmodule

### tb/imu_lowpass_checker.sv
`timescale 1ns / 1ps

module imu_lowpass_checker #(
  parameter int FRACTION_BITS = ioal_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  ioal_in_if                              samples,
  ioal_out_if                             results,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [ioal_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ioal_pkg::APB_DATA_W-1:0] pwdata,
  output int                              mismatches,
  output int                              outstanding
);
  import ioal_pkg::*;

  typedef struct packed {
    logic [1:0]              sensor;
    logic [1:0]              axis;
    logic signed [OUT_W-1:0] value;
  } lowpass_result_t;

  lowpass_result_t filtered_expected[$];

  logic [ALPHA_W-1:0]         alpha;
  logic signed [SAMPLE_W-1:0] gyro_offset[3];
  logic                       invert_accel;
  longint                     lowpass_state[NUM_CHANNELS];

  // Advances the channel's filter by one sample and returns the reported value.
  function automatic lowpass_result_t predict_lowpass(input logic [1:0] sensor,
                                                      input logic [1:0] axis,
                                                      input logic [7:0] first_byte,
                                                      input logic [7:0] second_byte);
    lowpass_result_t r;
    logic [SAMPLE_W-1:0] word;
    longint raw;
    longint diff;
    longint weight;
    longint level;
    int ch;
    word = (sensor == SENSOR_ACCEL) ? {second_byte, first_byte} : {first_byte, second_byte};
    raw = longint'($signed(word));
    if (sensor == SENSOR_GYRO) begin
      raw = raw - longint'(gyro_offset[axis]);
    end
    weight = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
    ch = int'(sensor) * 3 + int'(axis);
    diff = (raw <<< FRACTION_BITS) - lowpass_state[ch];
    // Arithmetic shift of a signed product floors toward minus infinity.
    lowpass_state[ch] = lowpass_state[ch] + ((diff * weight) >>> 16);
    level = lowpass_state[ch];
    if (sensor == SENSOR_ACCEL && axis != AXIS_Y && invert_accel) begin
      level = -level;
    end
    r.sensor = sensor;
    r.axis = axis;
    r.value = level[OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    lowpass_result_t got;
    lowpass_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      alpha = ALPHA_RESET;
      gyro_offset[0] = '0;
      gyro_offset[1] = '0;
      gyro_offset[2] = '0;
      invert_accel = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        lowpass_state[i] = 0;
      end
      filtered_expected.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[APB_ADDR_W-1:2]))
          REG_ALPHA_Q16:     alpha = pwdata[ALPHA_W-1:0];
          REG_GYRO_OFFSET_X: gyro_offset[AXIS_X] = pwdata[SAMPLE_W-1:0];
          REG_GYRO_OFFSET_Y: gyro_offset[AXIS_Y] = pwdata[SAMPLE_W-1:0];
          REG_GYRO_OFFSET_Z: gyro_offset[AXIS_Z] = pwdata[SAMPLE_W-1:0];
          REG_INVERT_ACCEL:  invert_accel = pwdata[0];
          default: ;
        endcase
      end

      if (results.valid && results.ready) begin
        got.sensor = results.out_sensor;
        got.axis = results.out_axis;
        got.value = results.filtered_value;
        if (filtered_expected.size() == 0) begin
          $error("unexpected result: sensor %0d axis %0d value %0d",
                 got.sensor, got.axis, $signed(got.value));
          errs++;
        end else begin
          want = filtered_expected.pop_front();
          if (got.sensor !== want.sensor) begin
            $error("out_sensor mismatch: expected %0d, got %0d", want.sensor, got.sensor);
            errs++;
          end
          if (got.axis !== want.axis) begin
            $error("out_axis mismatch: expected %0d, got %0d", want.axis, got.axis);
            errs++;
          end
          if (got.value !== want.value) begin
            $error("filtered_value mismatch: expected %0d, got %0d",
                   $signed(want.value), $signed(got.value));
            errs++;
          end
        end
      end

      // Codes outside the sensor and axis range are dropped by the block.
      if (samples.valid && samples.ready &&
          samples.sensor <= SENSOR_MAG && samples.axis <= AXIS_Z) begin
        filtered_expected.push_back(predict_lowpass(samples.sensor, samples.axis,
                                                    samples.first_byte,
                                                    samples.second_byte));
      end
    end
    mismatches <= mismatches + errs;
    outstanding <= filtered_expected.size();
  end

endmodule

### tb/imu_axis_offset_lowpass_test.sv
`timescale 1ns / 1ps

module imu_axis_offset_lowpass_test;
  import ioal_pkg::*;

  localparam int FRACTION_BITS = FRACTION_BITS_DEFAULT;
  localparam logic [1:0] SENSOR_NONE = 2'd3;
  localparam logic [1:0] AXIS_NONE = 2'd3;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatch_count;
  int outstanding;
  int cycles = 0;

  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int send_run = 0;
  bit send_calm = 1'b0;
  int drain_run = 0;
  bit drain_calm = 1'b0;

  ioal_in_if samples();
  ioal_out_if results();

  imu_axis_offset_lowpass #(
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples),
    .results(results),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  imu_lowpass_checker #(
    .FRACTION_BITS(FRACTION_BITS)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .results    (results),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatch_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("imu_axis_offset_lowpass_test NOT OK");
      $finish;
    end
  end

  // Idle time comes in runs: some stretches have no gaps at all.
  task automatic draw_gap(inout int run_left, inout bit calm, output int gap);
    if (run_left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(8, 40);
    end
    run_left--;
    gap = calm ? 0 : $urandom_range(0, 13);
  endtask

  task automatic push_sample(input logic [1:0] sensor, input logic [1:0] axis,
                             input logic [7:0] b0, input logic [7:0] b1);
    int gap;
    draw_gap(send_run, send_calm, gap);
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.sensor <= sensor;
    samples.axis <= axis;
    samples.first_byte <= b0;
    samples.second_byte <= b1;
    do @(posedge clk); while (!samples.ready);
  endtask

  // Called in the step of the last transaction, so valid drops right away.
  task automatic finish_phase();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic configure_phase(input int ph);
    logic [APB_DATA_W-1:0] weight;
    case (ph % 6)
      0: weight = 32'(ALPHA_ONE);
      1: weight = $urandom_range(40000, 65535);
      2: weight = $urandom_range(1, 255);
      3: weight = $urandom_range(65537, 131071);
      4: weight = $urandom_range(0, 65535);
      default: weight = 32'(ALPHA_RESET);
    endcase
    write_reg(REG_ALPHA_Q16, weight);
    write_reg(REG_GYRO_OFFSET_X, pick_offset());
    write_reg(REG_GYRO_OFFSET_Y, pick_offset());
    write_reg(REG_GYRO_OFFSET_Z, pick_offset());
    write_reg(REG_INVERT_ACCEL, ph % 2);
  endtask

  initial begin : drain
    int gap;
    results.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // One long hold-off lets the pipeline fill and back up into the input.
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        results.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      draw_gap(drain_run, drain_calm, gap);
      if (gap > 0) begin
        results.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
    end
  end

  initial begin : stimulus
    logic [1:0] sensor;
    logic [1:0] axis;
    int sent;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samples.valid = 1'b0;
    samples.sensor = SENSOR_ACCEL;
    samples.axis = AXIS_X;
    samples.first_byte = '0;
    samples.second_byte = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults: byte order per sensor, full-scale words, dropped codes.
    push_sample(SENSOR_ACCEL, AXIS_X, 8'h00, 8'h80);
    push_sample(SENSOR_ACCEL, AXIS_Y, 8'hFF, 8'h7F);
    push_sample(SENSOR_ACCEL, AXIS_Z, 8'h01, 8'h00);
    push_sample(SENSOR_GYRO, AXIS_X, 8'h80, 8'h00);
    push_sample(SENSOR_GYRO, AXIS_Y, 8'h7F, 8'hFF);
    push_sample(SENSOR_GYRO, AXIS_Z, 8'hFF, 8'hFF);
    push_sample(SENSOR_MAG, AXIS_X, 8'h00, 8'h00);
    push_sample(SENSOR_MAG, AXIS_Y, 8'hFF, 8'hFE);
    push_sample(SENSOR_MAG, AXIS_Z, 8'h7F, 8'hFF);
    push_sample(SENSOR_NONE, AXIS_X, 8'h12, 8'h34);
    push_sample(SENSOR_ACCEL, AXIS_NONE, 8'h56, 8'h78);
    push_sample(SENSOR_GYRO, AXIS_X, 8'h80, 8'h00);
    push_sample(SENSOR_GYRO, AXIS_X, 8'h7F, 8'hFF);
    finish_phase();

    // Offsets at the extremes push the gyro difference past 16 bits.
    write_reg(REG_GYRO_OFFSET_X, 32767);
    write_reg(REG_GYRO_OFFSET_Y, -32768);
    write_reg(REG_GYRO_OFFSET_Z, -1);
    write_reg(REG_INVERT_ACCEL, 1);
    write_reg(REG_ALPHA_Q16, 32'(ALPHA_ONE));
    push_sample(SENSOR_GYRO, AXIS_X, 8'h80, 8'h00);
    push_sample(SENSOR_GYRO, AXIS_Y, 8'h7F, 8'hFF);
    push_sample(SENSOR_GYRO, AXIS_Z, 8'h00, 8'h05);
    push_sample(SENSOR_ACCEL, AXIS_X, 8'h34, 8'h12);
    push_sample(SENSOR_ACCEL, AXIS_Z, 8'hCD, 8'hAB);
    push_sample(SENSOR_ACCEL, AXIS_Y, 8'h00, 8'h80);
    finish_phase();

    // A zero weight freezes the state.
    write_reg(REG_ALPHA_Q16, 0);
    push_sample(SENSOR_MAG, AXIS_X, 8'h12, 8'h34);
    push_sample(SENSOR_ACCEL, AXIS_X, 8'hFF, 8'h7F);
    finish_phase();

    // Weights above one saturate to one.
    write_reg(REG_ALPHA_Q16, 131071);
    push_sample(SENSOR_MAG, AXIS_X, 8'h80, 8'h00);
    push_sample(SENSOR_GYRO, AXIS_Y, 8'h00, 8'h00);
    finish_phase();

    write_reg(REG_INVERT_ACCEL, 0);
    write_reg(REG_ALPHA_Q16, 1);
    push_sample(SENSOR_ACCEL, AXIS_Z, 8'h80, 8'h00);
    push_sample(SENSOR_ACCEL, AXIS_X, 8'hFF, 8'hFF);
    finish_phase();

    sensor = SENSOR_ACCEL;
    axis = AXIS_X;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      configure_phase(ph);
      if (ph == 1) begin
        long_hold_req <= 1'b1;
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // Repeat the channel now and then so one filter sees runs of samples.
        if ($urandom_range(0, 2) != 0 || sensor > SENSOR_MAG || axis > AXIS_Z) begin
          sensor = ($urandom_range(0, 19) == 0) ? SENSOR_NONE : 2'($urandom_range(0, 2));
          axis = ($urandom_range(0, 19) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
        end
        push_sample(sensor, axis, pick_byte(), pick_byte());
        if (sensor <= SENSOR_MAG && axis <= AXIS_Z) begin
          sent++;
        end
      end
      finish_phase();
    end

    if (mismatch_count == 0) begin
      $display("imu_axis_offset_lowpass_test OK");
    end else begin
      $display("imu_axis_offset_lowpass_test NOT OK");
    end
    $finish;
  end

endmodule
